>>> design/least_served_queue_arbiter_defines.svh
// Assertion macros for the least-served queue arbiter.
// No dependencies; included by the modules that carry assertions.
`ifndef LEAST_SERVED_QUEUE_ARBITER_DEFINES_SVH
`define LEAST_SERVED_QUEUE_ARBITER_DEFINES_SVH

// same-cycle implication
`define LSQA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSQA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lsqa_pkg.sv
// Shared types and constants for the least-served queue arbiter.
// No dependencies; used by lsqa_ctrl, lsqa_datapath and the top level.
package lsqa_pkg;

    localparam int NUM_QUEUES  = 4;
    localparam int QIDX_W      = 2;
    localparam int MASK_W      = 4;
    localparam int BOOST_W     = 8;
    localparam int TOTAL_W     = 10;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BOOST_AMOUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFERRED_MASK = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SELECT     = 2'd0,
        CMD_BOOST_PREF = 2'd1,
        CMD_BOOST_LAST = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_SCAN,
        DP_GRANT,
        DP_BOOST,
        DP_BOOST_LAST
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GRANT,
        ST_BOOST,
        ST_BOOST_LAST,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic   load_item;
        dp_op_t op;
        logic   load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> design/lsqa_ctrl.sv
// Controller state machine for the least-served queue arbiter.
// Depends on lsqa_pkg; drives lsqa_datapath through dp_cmd_t.
module lsqa_ctrl
    import lsqa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  dp_status_t         status,
    output dp_cmd_t            dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        dp_cmd.load_item = 1'b0;
        dp_cmd.op        = DP_IDLE;
        dp_cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load_item = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_SELECT:     state_next = ST_SCAN;
                        CMD_BOOST_PREF: state_next = ST_BOOST;
                        CMD_BOOST_LAST: state_next = ST_BOOST_LAST;
                        default:        state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                dp_cmd.op = DP_SCAN;
                if (status.walk_last)
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                dp_cmd.op  = DP_GRANT;
                state_next = ST_FINISH;
            end
            ST_BOOST:
            begin
                dp_cmd.op = DP_BOOST;
                if (status.walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BOOST_LAST:
            begin
                dp_cmd.op  = DP_BOOST_LAST;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/lsqa_datapath.sv
// Datapath for the least-served queue arbiter: counters, scan, boost, output word.
// Depends on lsqa_pkg and least_served_queue_arbiter_defines.svh.
`include "least_served_queue_arbiter_defines.svh"

module lsqa_datapath
    import lsqa_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [MASK_W-1:0]      nonempty_mask,
    input  dp_cmd_t                dp_cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [QIDX_W-1:0]      grant_index,
    output logic                   grant_valid,
    output logic [TOTAL_W-1:0]     boost_sum
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNTER_WIDTH-1){1'b1}}};
    localparam logic [COUNTER_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNTER_WIDTH-1){1'b0}}};

    logic [BOOST_W-1:0]       boost_amount_reg;
    logic [MASK_W-1:0]        pref_mask_reg;
    logic [COUNTER_WIDTH-1:0] counter_reg [NUM_QUEUES];
    logic [QIDX_W-1:0]        last_grant_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic [QIDX_W-1:0]        idx_reg;
    logic                     found_reg;
    logic [QIDX_W-1:0]        best_idx_reg;
    logic [COUNTER_WIDTH-1:0] best_val_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     out_valid_reg;
    logic [QIDX_W-1:0]        grant_index_reg;
    logic                     grant_valid_reg;
    logic [TOTAL_W-1:0]       boost_sum_reg;

    logic [QIDX_W-1:0]        rd_idx;
    logic [COUNTER_WIDTH-1:0] rd_value;
    logic [COUNTER_WIDTH:0]   sub_ext;
    logic [COUNTER_WIDTH-1:0] inc_value;
    logic [COUNTER_WIDTH-1:0] dec_value;
    logic [COUNTER_WIDTH-1:0] wr_value;
    logic                     wr_en;
    logic                     scan_take;

    always_comb
    begin
        case (dp_cmd.op)
            DP_GRANT:      rd_idx = best_idx_reg;
            DP_BOOST_LAST: rd_idx = last_grant_reg;
            default:       rd_idx = idx_reg;
        endcase
    end

    assign rd_value  = counter_reg[rd_idx];
    assign inc_value = (rd_value == CNT_MAX) ? CNT_MAX : rd_value + COUNTER_WIDTH'(1);
    assign sub_ext   = {rd_value[COUNTER_WIDTH-1], rd_value}
                     - {{(COUNTER_WIDTH+1-BOOST_W){1'b0}}, boost_amount_reg};
    assign dec_value = (sub_ext[COUNTER_WIDTH] != sub_ext[COUNTER_WIDTH-1])
                     ? CNT_MIN : sub_ext[COUNTER_WIDTH-1:0];
    assign scan_take = mask_reg[idx_reg]
                     && (!found_reg || ($signed(rd_value) < $signed(best_val_reg)));

    always_comb
    begin
        wr_en    = 1'b0;
        wr_value = dec_value;
        case (dp_cmd.op)
            DP_GRANT:
            begin
                wr_en    = found_reg;
                wr_value = inc_value;
            end
            DP_BOOST:      wr_en = pref_mask_reg[idx_reg];
            DP_BOOST_LAST: wr_en = 1'b1;
            default:       wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boost_amount_reg <= '0;
            pref_mask_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BOOST_AMOUNT:   boost_amount_reg <= cfg_data[BOOST_W-1:0];
                REG_PREFERRED_MASK: pref_mask_reg    <= cfg_data[MASK_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                counter_reg[i] <= '0;
            end
            last_grant_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                counter_reg[rd_idx] <= wr_value;
            end
            if (dp_cmd.op == DP_GRANT && found_reg)
            begin
                last_grant_reg <= best_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        else if (dp_cmd.load_item)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            if (dp_cmd.op == DP_SCAN || dp_cmd.op == DP_BOOST)
            begin
                idx_reg <= idx_reg + QIDX_W'(1);
            end
            if (dp_cmd.op == DP_SCAN && scan_take)
            begin
                found_reg <= 1'b1;
            end
            if (dp_cmd.op == DP_BOOST && pref_mask_reg[idx_reg])
            begin
                total_reg <= total_reg + {{(TOTAL_W-BOOST_W){1'b0}}, boost_amount_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_item)
        begin
            mask_reg <= nonempty_mask;
        end
        if (dp_cmd.op == DP_SCAN && scan_take)
        begin
            best_idx_reg <= idx_reg;
            best_val_reg <= rd_value;
        end
        if (dp_cmd.load_out)
        begin
            grant_index_reg <= last_grant_reg;
            grant_valid_reg <= found_reg;
            boost_sum_reg   <= total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.walk_last = (idx_reg == QIDX_W'(NUM_QUEUES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign grant_index = grant_index_reg;
    assign grant_valid = grant_valid_reg;
    assign boost_sum   = boost_sum_reg;

    `LSQA_ASSERT_NOW(a_load_when_free, clk, rst_n,
        dp_cmd.load_out, status.out_free, "result word loaded over a pending one")
    `LSQA_ASSERT_NOW(a_grant_no_total, clk, rst_n,
        out_valid_reg && grant_valid_reg, boost_sum_reg == '0,
        "grant word carries a boost total")
    `LSQA_ASSERT_NEXT(a_grant_records, clk, rst_n,
        dp_cmd.op == DP_GRANT && found_reg, last_grant_reg == $past(best_idx_reg),
        "granted queue not recorded as last grant")

endmodule

>>> design/least_served_queue_arbiter.sv
// Least-served queue arbiter. One item is in flight at a time, and a select walks
// the counters one per cycle.
// A result word may wait at the output while the next word is accepted.
// rst_n (asynchronous, active low) clears all counters, the last grant and the
// configuration registers to zero.
module least_served_queue_arbiter
    import lsqa_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [MASK_W-1:0]      nonempty_mask,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [QIDX_W-1:0]      grant_index,
    output logic                   grant_valid,
    output logic [TOTAL_W-1:0]     boost_sum
);

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    lsqa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    lsqa_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .nonempty_mask (nonempty_mask),
        .dp_cmd        (dp_cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .grant_index   (grant_index),
        .grant_valid   (grant_valid),
        .boost_sum     (boost_sum)
    );

endmodule
